// ===== hw/rtl/par_pkg.sv =====
// ----------------------------------------------------------------------------
// Point axis rotator package
// Shared constants, axis codes, control struct and the CORDIC angle table.
// ----------------------------------------------------------------------------
package par_pkg;

  localparam int COORD_WIDTH_DEF   = 24;
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // extra fraction bits carried through the shift-add stages
  localparam int GUARD_BITS = 16;
  // phase accumulator: 2^32 units per turn
  localparam int PHASE_W    = 32;
  // residual angle, signed, with headroom for the table sum
  localparam int RES_W      = 34;
  localparam int ATAN_LEN   = 24;

  localparam logic [PHASE_W-1:0] PHASE_EIGHTH = 32'h2000_0000;
  localparam logic [31:0]        GAIN_Q32     = 32'h9B74_EDA8;

  localparam logic [0:0] CFG_IDX_ANGLE = 1'b0;
  localparam logic [0:0] CFG_IDX_AXIS  = 1'b1;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } par_axis_t;

  typedef struct packed {
    logic      vld;
    par_axis_t axis;
  } par_ctl_t;

  // round(atan(2^-i) * 2^32 / (2*pi))
  function automatic logic [31:0] par_atan(input int idx);
    logic [31:0] t;
    case (idx)
      0:       t = 32'h2000_0000;
      1:       t = 32'h12E4_051E;
      2:       t = 32'h09FB_385B;
      3:       t = 32'h0511_11D4;
      4:       t = 32'h028B_0D43;
      5:       t = 32'h0145_D7E1;
      6:       t = 32'h00A2_F61E;
      7:       t = 32'h0051_7C55;
      8:       t = 32'h0028_BE53;
      9:       t = 32'h0014_5F2F;
      10:      t = 32'h000A_2F98;
      11:      t = 32'h0005_17CC;
      12:      t = 32'h0002_8BE6;
      13:      t = 32'h0001_45F3;
      14:      t = 32'h0000_A2FA;
      15:      t = 32'h0000_517D;
      16:      t = 32'h0000_28BE;
      17:      t = 32'h0000_145F;
      18:      t = 32'h0000_0A30;
      19:      t = 32'h0000_0518;
      20:      t = 32'h0000_028C;
      21:      t = 32'h0000_0146;
      22:      t = 32'h0000_00A3;
      23:      t = 32'h0000_0051;
      default: t = 32'h0000_0000;
    endcase
    return t;
  endfunction

endpackage

// ===== hw/rtl/par_in_if.sv =====
// ----------------------------------------------------------------------------
// Point input channel
// Valid/ready channel carrying one input point per word.
// ----------------------------------------------------------------------------
interface par_in_if #(
  parameter int COORD_WIDTH = par_pkg::COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_in;
  logic signed [COORD_WIDTH-1:0] y_in;
  logic signed [COORD_WIDTH-1:0] z_in;

  modport source (output valid, output x_in, output y_in, output z_in, input ready);
  modport sink   (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

// ===== hw/rtl/par_out_if.sv =====
// ----------------------------------------------------------------------------
// Point result channel
// Valid/ready channel carrying one rotated point per word.
// ----------------------------------------------------------------------------
interface par_out_if #(
  parameter int COORD_WIDTH = par_pkg::COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_out;
  logic signed [COORD_WIDTH-1:0] y_out;
  logic signed [COORD_WIDTH-1:0] z_out;

  modport source (output valid, output x_out, output y_out, output z_out, input ready);
  modport sink   (input valid, input x_out, input y_out, input z_out, output ready);
endinterface

// ===== hw/rtl/point_axis_rotator_top.sv =====
// ----------------------------------------------------------------------------
// Point axis rotator
// Streams 3D points and turns each about the X, Y or Z axis with a pipelined
// CORDIC.
// ----------------------------------------------------------------------------
// The block takes one point word per clock while the input is ready and
// returns one rotated point word per accepted point, in order, through one
// front stage that picks the pair and quadrant, one register stage per
// CORDIC micro-rotation, and four gain stages (magnitude, split 32-bit
// multiply, round, saturate). Every stage carries its own valid
// bit and loads whenever it is empty or its successor moves, so a stalled
// output only holds back the stages behind it until their bubbles fill; the
// input stays ready as long as any stage is free. Axis X turns (y,z), Y turns
// (z,x), Z turns (x,y); axis code 3 passes the point through. Angle and axis
// are captured with each point at the input, and should be written only
// while the pipe is empty.
// ----------------------------------------------------------------------------
module point_axis_rotator_top #(
  parameter int COORD_WIDTH   = par_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = par_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = par_pkg::CORDIC_STAGES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [0:0]             cfg_index,
  input  logic [ANGLE_WIDTH-1:0] cfg_wdata,
  par_in_if.sink                 in_pt,
  par_out_if.source              out_pt
);
  import par_pkg::*;

  // pair width: coordinate, guard fraction, pre-rotation and CORDIC growth
  localparam int DATA_W = (COORD_WIDTH + GUARD_BITS + 3 > 33) ?
                          (COORD_WIDTH + GUARD_BITS + 3) : 33;
  localparam int NS     = CORDIC_STAGES;
  localparam int NT     = NS + 5;  // total register stages

  // configuration
  logic [ANGLE_WIDTH-1:0] angle_r;
  par_axis_t              axis_r;

  // CORDIC chain, index 0 is the front stage output
  par_ctl_t                 stg_ctl [NS+1];
  logic signed [DATA_W-1:0] stg_a   [NS+1];
  logic signed [DATA_W-1:0] stg_b   [NS+1];
  logic signed [RES_W-1:0]  stg_res [NS+1];
  logic [3*COORD_WIDTH-1:0] stg_pt  [NS+1];

  logic [3:0]    gain_vld;
  logic [NT-1:0] stage_vld;
  logic [NT-1:0] en;
  logic          in_acc;
  logic          out_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
      axis_r  <= AXIS_Z;
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDX_ANGLE) begin
        angle_r <= cfg_wdata;
      end else if (cfg_index == CFG_IDX_AXIS) begin
        axis_r <= par_axis_t'(cfg_wdata[1:0]);
      end
    end
  end

  // per-stage advance: a stage loads when it is empty or its successor loads
  assign en[NT-1] = !stage_vld[NT-1] || out_pt.ready;
  genvar k;
  generate
    for (k = 0; k < NT - 1; k++) begin : g_en
      assign en[k] = !stage_vld[k] || en[k+1];
    end
    for (k = 0; k <= NS; k++) begin : g_vld
      assign stage_vld[k] = stg_ctl[k].vld;
    end
  endgenerate
  assign stage_vld[NT-1:NS+1] = gain_vld;

  assign in_pt.ready = en[0];
  assign in_acc      = in_pt.valid && in_pt.ready;
  assign out_acc     = out_pt.valid && out_pt.ready;

  par_pre #(
    .COORD_WIDTH (COORD_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .DATA_W      (DATA_W)
  ) u_pre (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en[0]),
    .in_vld (in_pt.valid),
    .angle  (angle_r),
    .axis   (axis_r),
    .x      (in_pt.x_in),
    .y      (in_pt.y_in),
    .z      (in_pt.z_in),
    .ctl_r  (stg_ctl[0]),
    .a_r    (stg_a[0]),
    .b_r    (stg_b[0]),
    .res_r  (stg_res[0]),
    .pt_r   (stg_pt[0])
  );

  generate
    for (k = 0; k < NS; k++) begin : g_stage
      par_stage #(
        .COORD_WIDTH (COORD_WIDTH),
        .DATA_W      (DATA_W),
        .IDX         (k)
      ) u_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en[k+1]),
        .ctl_i (stg_ctl[k]),
        .a_i   (stg_a[k]),
        .b_i   (stg_b[k]),
        .res_i (stg_res[k]),
        .pt_i  (stg_pt[k]),
        .ctl_r (stg_ctl[k+1]),
        .a_r   (stg_a[k+1]),
        .b_r   (stg_b[k+1]),
        .res_r (stg_res[k+1]),
        .pt_r  (stg_pt[k+1])
      );
    end
  endgenerate

  // final residual is not needed past the last micro-rotation
  par_gain #(
    .COORD_WIDTH (COORD_WIDTH),
    .DATA_W      (DATA_W)
  ) u_gain (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en[NT-1:NS+1]),
    .ctl_i (stg_ctl[NS]),
    .a_i   (stg_a[NS]),
    .b_i   (stg_b[NS]),
    .pt_i  (stg_pt[NS]),
    .vld   (gain_vld),
    .x_r   (out_pt.x_out),
    .y_r   (out_pt.y_out),
    .z_r   (out_pt.z_out)
  );

  assign out_pt.valid = stage_vld[NT-1];

  // pipe is empty right after reset
  a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (stage_vld == '0))
    else $error("pipeline holds words after reset");

  // words in flight change only by accepted input and delivered output
  a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(stage_vld) ==
      $past($countones(stage_vld)) + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("word lost or duplicated in pipeline");

  // a full, stalled pipe must not take input
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ((&stage_vld) && !out_pt.ready) |-> !in_pt.ready)
    else $error("input accepted into a full stalled pipe");

  // a stalled output word keeps its stage valid
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pt.valid && !out_pt.ready) |=> stage_vld[NT-1])
    else $error("stalled output stage dropped its word");

endmodule

// ===== hw/rtl/par_pre.sv =====
// ----------------------------------------------------------------------------
// Point axis rotator front stage
// Picks the coordinate pair for the axis, splits the angle into quadrant and
// residual, and applies the quarter-turn pre-rotation.
// ----------------------------------------------------------------------------
module par_pre #(
  parameter int COORD_WIDTH = par_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = par_pkg::ANGLE_WIDTH_DEF,
  parameter int DATA_W      = 43
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic [ANGLE_WIDTH-1:0]          angle,
  input  par_pkg::par_axis_t              axis,
  input  logic signed [COORD_WIDTH-1:0]   x,
  input  logic signed [COORD_WIDTH-1:0]   y,
  input  logic signed [COORD_WIDTH-1:0]   z,
  output par_pkg::par_ctl_t               ctl_r,
  output logic signed [DATA_W-1:0]        a_r,
  output logic signed [DATA_W-1:0]        b_r,
  output logic signed [par_pkg::RES_W-1:0] res_r,
  output logic [3*COORD_WIDTH-1:0]        pt_r
);
  import par_pkg::*;

  localparam int EXT_W = DATA_W - COORD_WIDTH - 1 - GUARD_BITS;

  logic [PHASE_W-1:0]            phase;
  logic [PHASE_W-1:0]            rnd;
  logic [PHASE_W-1:0]            ru;
  logic [1:0]                    quad;
  logic signed [COORD_WIDTH-1:0] src_a;
  logic signed [COORD_WIDTH-1:0] src_b;
  logic signed [COORD_WIDTH:0]   sa;
  logic signed [COORD_WIDTH:0]   sb;
  logic signed [COORD_WIDTH:0]   pa;
  logic signed [COORD_WIDTH:0]   pb;
  par_ctl_t                      ctl_nxt;
  logic signed [DATA_W-1:0]      a_nxt;
  logic signed [DATA_W-1:0]      b_nxt;
  logic signed [RES_W-1:0]       res_nxt;

  always_comb begin
    phase   = {angle, {(PHASE_W-ANGLE_WIDTH){1'b0}}};
    rnd     = phase + PHASE_EIGHTH;
    quad    = rnd[PHASE_W-1:PHASE_W-2];
    ru      = phase - {quad, {(PHASE_W-2){1'b0}}};
    res_nxt = {{(RES_W-PHASE_W){ru[PHASE_W-1]}}, ru};

    unique case (axis) inside
      AXIS_X: begin
        src_a = y;
        src_b = z;
      end
      AXIS_Y: begin
        src_a = z;
        src_b = x;
      end
      AXIS_Z, AXIS_NONE: begin
        src_a = x;
        src_b = y;
      end
      default: begin
        src_a = x;
        src_b = y;
      end
    endcase

    sa = {src_a[COORD_WIDTH-1], src_a};
    sb = {src_b[COORD_WIDTH-1], src_b};

    case (quad)
      2'd1: begin
        pa = -sb;
        pb = sa;
      end
      2'd2: begin
        pa = -sa;
        pb = -sb;
      end
      2'd3: begin
        pa = sb;
        pb = -sa;
      end
      default: begin
        pa = sa;
        pb = sb;
      end
    endcase

    a_nxt = {{EXT_W{pa[COORD_WIDTH]}}, pa, {GUARD_BITS{1'b0}}};
    b_nxt = {{EXT_W{pb[COORD_WIDTH]}}, pb, {GUARD_BITS{1'b0}}};

    ctl_nxt.vld  = in_vld;
    ctl_nxt.axis = axis;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      res_r <= res_nxt;
      pt_r  <= {z, y, x};
    end
  end

endmodule

// ===== hw/rtl/par_stage.sv =====
// ----------------------------------------------------------------------------
// Point axis rotator CORDIC stage
// One registered shift-add micro-rotation, steered by the residual sign.
// ----------------------------------------------------------------------------
module par_stage #(
  parameter int COORD_WIDTH = par_pkg::COORD_WIDTH_DEF,
  parameter int DATA_W      = 43,
  parameter int IDX         = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  par_pkg::par_ctl_t                ctl_i,
  input  logic signed [DATA_W-1:0]         a_i,
  input  logic signed [DATA_W-1:0]         b_i,
  input  logic signed [par_pkg::RES_W-1:0] res_i,
  input  logic [3*COORD_WIDTH-1:0]         pt_i,
  output par_pkg::par_ctl_t                ctl_r,
  output logic signed [DATA_W-1:0]         a_r,
  output logic signed [DATA_W-1:0]         b_r,
  output logic signed [par_pkg::RES_W-1:0] res_r,
  output logic [3*COORD_WIDTH-1:0]         pt_r
);
  import par_pkg::*;

  localparam logic signed [RES_W-1:0] ANG = {{(RES_W-32){1'b0}}, par_atan(IDX)};

  logic signed [DATA_W-1:0] da;
  logic signed [DATA_W-1:0] db;
  logic signed [DATA_W-1:0] a_nxt;
  logic signed [DATA_W-1:0] b_nxt;
  logic signed [RES_W-1:0]  res_nxt;

  always_comb begin
    da = b_i >>> IDX;
    db = a_i >>> IDX;
    if (!res_i[RES_W-1]) begin
      a_nxt   = a_i - da;
      b_nxt   = b_i + db;
      res_nxt = res_i - ANG;
    end else begin
      a_nxt   = a_i + da;
      b_nxt   = b_i - db;
      res_nxt = res_i + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      res_r <= res_nxt;
      pt_r  <= pt_i;
    end
  end

endmodule

// ===== hw/rtl/par_gain.sv =====
// ----------------------------------------------------------------------------
// Point axis rotator gain stages
// Four stages: magnitude, split multiply by the CORDIC gain, sum and round,
// then sign, saturation and mapping back to x/y/z.
// ----------------------------------------------------------------------------
module par_gain #(
  parameter int COORD_WIDTH = par_pkg::COORD_WIDTH_DEF,
  parameter int DATA_W      = 43
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [3:0]                    en,
  input  par_pkg::par_ctl_t             ctl_i,
  input  logic signed [DATA_W-1:0]      a_i,
  input  logic signed [DATA_W-1:0]      b_i,
  input  logic [3*COORD_WIDTH-1:0]      pt_i,
  output logic [3:0]                    vld,
  output logic signed [COORD_WIDTH-1:0] x_r,
  output logic signed [COORD_WIDTH-1:0] y_r,
  output logic signed [COORD_WIDTH-1:0] z_r
);
  import par_pkg::*;

  localparam int HI_W   = DATA_W - 32;
  localparam int PROD_W = HI_W + 32;
  localparam int SUM_W  = HI_W + 33;
  localparam int RND_W  = HI_W + 17;
  localparam logic [SUM_W-1:0] HALF_LSB = SUM_W'(64'd1 << (GUARD_BITS - 1));
  localparam logic [RND_W-1:0] MAX_POS  = RND_W'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
  localparam logic [RND_W-1:0] MIN_MAG  = RND_W'(64'd1 << (COORD_WIDTH - 1));

  par_ctl_t                   ctl1_r, ctl2_r, ctl3_r;
  logic                       vld4_r;
  logic [1:0]                 neg1_r, neg2_r, neg3_r;
  logic [3*COORD_WIDTH-1:0]   pt1_r, pt2_r, pt3_r;
  logic [DATA_W-1:0]          mag1_r [2];
  logic [DATA_W-1:0]          mag1_nxt [2];
  logic [63:0]                plo2_r [2];
  logic [PROD_W-1:0]          phi2_r [2];
  logic [RND_W-1:0]           rnd3_r [2];
  logic [RND_W-1:0]           rnd3_nxt [2];
  logic [SUM_W-1:0]           sum [2];
  logic [COORD_WIDTH-1:0]     sat [2];
  logic [COORD_WIDTH-1:0]     px, py, pz;
  logic [COORD_WIDTH-1:0]     x_nxt, y_nxt, z_nxt;

  // stage 1: sign and magnitude
  always_comb begin
    mag1_nxt[0] = a_i[DATA_W-1] ? DATA_W'(-a_i) : DATA_W'(a_i);
    mag1_nxt[1] = b_i[DATA_W-1] ? DATA_W'(-b_i) : DATA_W'(b_i);
  end

  // stage 3: floor(m*K/2^32), then round at the guard point
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sum[l]      = {1'b0, phi2_r[l]} + SUM_W'(plo2_r[l][63:32]) + HALF_LSB;
      rnd3_nxt[l] = sum[l][SUM_W-1:GUARD_BITS];
    end
  end

  // stage 4: saturate on the magnitude, apply sign, place the pair
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (!neg3_r[l] && (rnd3_r[l] > MAX_POS)) begin
        sat[l] = MAX_POS[COORD_WIDTH-1:0];
      end else if (neg3_r[l] && (rnd3_r[l] > MIN_MAG)) begin
        sat[l] = MIN_MAG[COORD_WIDTH-1:0];
      end else if (neg3_r[l]) begin
        sat[l] = -rnd3_r[l][COORD_WIDTH-1:0];
      end else begin
        sat[l] = rnd3_r[l][COORD_WIDTH-1:0];
      end
    end

    px = pt3_r[COORD_WIDTH-1:0];
    py = pt3_r[2*COORD_WIDTH-1:COORD_WIDTH];
    pz = pt3_r[3*COORD_WIDTH-1:2*COORD_WIDTH];

    unique case (ctl3_r.axis)
      AXIS_X: begin
        x_nxt = px;
        y_nxt = sat[0];
        z_nxt = sat[1];
      end
      AXIS_Y: begin
        x_nxt = sat[1];
        y_nxt = py;
        z_nxt = sat[0];
      end
      AXIS_Z: begin
        x_nxt = sat[0];
        y_nxt = sat[1];
        z_nxt = pz;
      end
      default: begin
        x_nxt = px;
        y_nxt = py;
        z_nxt = pz;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      vld4_r <= 1'b0;
    end else begin
      if (en[0]) ctl1_r <= ctl_i;
      if (en[1]) ctl2_r <= ctl1_r;
      if (en[2]) ctl3_r <= ctl2_r;
      if (en[3]) vld4_r <= ctl3_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg1_r <= {b_i[DATA_W-1], a_i[DATA_W-1]};
      pt1_r  <= pt_i;
      for (int l = 0; l < 2; l++) mag1_r[l] <= mag1_nxt[l];
    end
    if (en[1]) begin
      neg2_r <= neg1_r;
      pt2_r  <= pt1_r;
      for (int l = 0; l < 2; l++) begin
        plo2_r[l] <= 64'(mag1_r[l][31:0]) * 64'(GAIN_Q32);
        phi2_r[l] <= PROD_W'(mag1_r[l][DATA_W-1:32]) * PROD_W'(GAIN_Q32);
      end
    end
    if (en[2]) begin
      neg3_r <= neg2_r;
      pt3_r  <= pt2_r;
      for (int l = 0; l < 2; l++) rnd3_r[l] <= rnd3_nxt[l];
    end
    if (en[3]) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign vld = {vld4_r, ctl3_r.vld, ctl2_r.vld, ctl1_r.vld};

endmodule

// ===== dv/point_rotation_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Point rotation checker
// Watches the config port and both point channels. It predicts each rotated
// point when the word is accepted, then compares each result word with the
// oldest prediction, coordinate by coordinate.
// ----------------------------------------------------------------------------
module point_rotation_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [0:0]                          cfg_index,
  input  logic [par_pkg::ANGLE_WIDTH_DEF-1:0] cfg_wdata,
  par_in_if                                   in_pt,
  par_out_if                                  out_pt,
  output int                                  mismatch_count,
  output int                                  in_flight
);
  import par_pkg::*;

  localparam int CW     = COORD_WIDTH_DEF;
  localparam int AW     = ANGLE_WIDTH_DEF;
  localparam int STAGES = CORDIC_STAGES_DEF;

  localparam longint CMAX = (longint'(1) << (CW - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;
  localparam longint unsigned GAIN = 64'(GAIN_Q32);

  // atan(2^-i) in turns * 2^32, stage 0 in the low word
  localparam logic [16*32-1:0] ARCTAN_Q32 = {
    32'h0000_517D, 32'h0000_A2FA, 32'h0001_45F3, 32'h0002_8BE6,
    32'h0005_17CC, 32'h000A_2F98, 32'h0014_5F2F, 32'h0028_BE53,
    32'h0051_7C55, 32'h00A2_F61E, 32'h0145_D7E1, 32'h028B_0D43,
    32'h0511_11D4, 32'h09FB_385B, 32'h12E4_051E, 32'h2000_0000
  };

  typedef logic signed [CW-1:0] coord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;
  typedef struct packed {
    logic signed [63:0] a;
    logic signed [63:0] b;
  } pair_t;

  logic [AW-1:0] angle_cfg;
  par_axis_t     axis_cfg;
  point_t        expected_points[$];

  // gain compensation, magnitude rounded half away from zero, then clamp
  function automatic longint gain_sat(longint v);
    longint unsigned m;
    longint unsigned f;
    longint unsigned r;
    longint          s;
    m = (v < 0) ? -v : v;
    f = (m >> 32) * GAIN + (((m & 64'hFFFF_FFFF) * GAIN) >> 32);
    r = (f + 64'd32768) >> GUARD_BITS;
    s = (v < 0) ? -longint'(r) : longint'(r);
    if (s > CMAX) s = CMAX;
    if (s < CMIN) s = CMIN;
    return s;
  endfunction

  function automatic pair_t turn_pair(longint a_in, longint b_in, logic [31:0] phase);
    logic [1:0]  quad;
    logic [31:0] resid_u;
    longint      a;
    longint      b;
    longint      da;
    longint      db;
    longint      resid;
    pair_t       r;
    quad    = 2'((phase + PHASE_EIGHTH) >> 30);
    resid_u = phase - {quad, 30'h0};
    resid   = longint'($signed(resid_u));
    case (quad)
      2'd1: begin a = -b_in; b = a_in;  end
      2'd2: begin a = -a_in; b = -b_in; end
      2'd3: begin a = b_in;  b = -a_in; end
      default: begin a = a_in; b = b_in; end
    endcase
    a = a * (longint'(1) << GUARD_BITS);
    b = b * (longint'(1) << GUARD_BITS);
    for (int i = 0; i < STAGES; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (resid >= 0) begin
        a     = a - da;
        b     = b + db;
        resid = resid - longint'(ARCTAN_Q32[i*32 +: 32]);
      end else begin
        a     = a + da;
        b     = b - db;
        resid = resid + longint'(ARCTAN_Q32[i*32 +: 32]);
      end
    end
    r.a = gain_sat(a);
    r.b = gain_sat(b);
    return r;
  endfunction

  function automatic point_t rotate_point(point_t p, logic [AW-1:0] angle,
                                          par_axis_t axis);
    coord_t      px;
    coord_t      py;
    coord_t      pz;
    logic [31:0] phase;
    pair_t       t;
    point_t      r;
    px    = p.x;
    py    = p.y;
    pz    = p.z;
    phase = 32'(angle) << (32 - AW);
    r     = p;
    case (axis)
      AXIS_X: begin
        t   = turn_pair(longint'(py), longint'(pz), phase);
        r.y = coord_t'(t.a);
        r.z = coord_t'(t.b);
      end
      AXIS_Y: begin
        t   = turn_pair(longint'(pz), longint'(px), phase);
        r.z = coord_t'(t.a);
        r.x = coord_t'(t.b);
      end
      AXIS_Z: begin
        t   = turn_pair(longint'(px), longint'(py), phase);
        r.x = coord_t'(t.a);
        r.y = coord_t'(t.b);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_coord(input string field, input coord_t want, input coord_t got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    point_t got;
    point_t want;
    if (!rst_n) begin
      angle_cfg <= '0;
      axis_cfg  <= AXIS_Z;
      expected_points.delete();
      mismatch_count = 0;
      in_flight <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_ANGLE) angle_cfg <= cfg_wdata;
        if (cfg_index == CFG_IDX_AXIS)  axis_cfg  <= par_axis_t'(cfg_wdata[1:0]);
      end
      // pop before push: a word entering this edge can't be the one leaving
      if (out_pt.valid && out_pt.ready) begin
        got = '{out_pt.x_out, out_pt.y_out, out_pt.z_out};
        if (expected_points.size() == 0) begin
          $error("result word with no point pending: %0d %0d %0d", got.x, got.y, got.z);
          mismatch_count++;
        end else begin
          want = expected_points.pop_front();
          check_coord("x_out", want.x, got.x);
          check_coord("y_out", want.y, got.y);
          check_coord("z_out", want.z, got.z);
        end
      end
      if (in_pt.valid && in_pt.ready)
        expected_points.push_back(rotate_point('{in_pt.x_in, in_pt.y_in, in_pt.z_in},
                                               angle_cfg, axis_cfg));
      in_flight <= expected_points.size();
    end
  end

endmodule

// ===== dv/tb_point_axis_rotator_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Point axis rotator testbench
// Drives point words through the rotator under a range of angle and axis
// settings, with random sender gaps and receiver stalls. A checker beside the
// block predicts every rotated point and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_point_axis_rotator_top;
  import par_pkg::*;

  localparam int CW              = COORD_WIDTH_DEF;
  localparam int AW              = ANGLE_WIDTH_DEF;
  // front stage + one per micro-rotation + four gain stages
  localparam int PIPE_LATENCY    = CORDIC_STAGES_DEF + 5;
  localparam int LIMIT_CYCLES    = 200000;
  localparam int HOLD_CYCLES     = 300;
  localparam int NUM_PHASES      = 12;
  localparam int WORDS_PER_PHASE = 95;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic [0:0]    cfg_index;
  logic [AW-1:0] cfg_wdata;

  int send_idle_pct;
  int recv_stall_pct = 0;
  int hold_req_n     = 0;   // bumped by stimulus, each bump = one long stall
  int cycle_count    = 0;
  int fail_count;
  int in_flight;

  par_in_if  in_pt ();
  par_out_if out_pt ();

  point_axis_rotator_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_pt     (in_pt),
    .out_pt    (out_pt)
  );

  point_rotation_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_pt          (in_pt),
    .out_pt         (out_pt),
    .mismatch_count (fail_count),
    .in_flight      (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog, far above the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("** point_axis_rotator_top: FAILED **");
      $finish;
    end
  end

  // Result side. Random stalls at recv_stall_pct; a hold request blocks ready
  // for a long hold counted down here, so the pipe backs up into the input.
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    out_pt.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req_n != hold_seen) begin
        hold_seen = hold_req_n;
        hold_left = HOLD_CYCLES;
      end
      if (!rst_n) begin
        out_pt.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_pt.ready <= 1'b0;
      end else begin
        out_pt.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // One point word. Random gap first, then hold valid until taken.
  // valid stays high into the next word when no gap is drawn.
  task automatic send_word(input coord_t x, input coord_t y, input coord_t z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_pt.valid <= 1'b0;
      @(posedge clk);
    end
    in_pt.valid <= 1'b1;
    in_pt.x_in  <= x;
    in_pt.y_in  <= y;
    in_pt.z_in  <= z;
    @(posedge clk);
    while (!in_pt.ready) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted point has come back.
  // The first edge lets the checker count a word taken on the last edge.
  task automatic wait_drained();
    in_pt.valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  // Writes angle then axis on back-to-back edges. upper fills the unused
  // high bits of the axis word; the block keeps only the low two.
  task automatic set_rotation(input logic [AW-1:0] angle, input par_axis_t axis,
                              input logic [AW-1:0] upper);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_ANGLE;
    cfg_wdata <= angle;
    @(posedge clk);
    cfg_index <= CFG_IDX_AXIS;
    cfg_wdata <= {upper[AW-1:2], axis};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mix of small values, values near the rails and full-range noise.
  function automatic coord_t rand_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom_range(131071)) - coord_t'(65536);
      1: return $urandom_range(1) ? C_MAX - coord_t'($urandom_range(15))
                                  : C_MIN + coord_t'($urandom_range(15));
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Mostly any angle; sometimes within one unit of an eighth-turn, where
  // the quadrant pick flips.
  function automatic logic [AW-1:0] rand_angle();
    if ($urandom_range(2) == 0)
      return AW'($urandom_range(7) * (1 << (AW - 3)) + $urandom_range(2)) - AW'(1);
    return AW'($urandom);
  endfunction

  initial begin : stimulus
    int        mode;
    par_axis_t axis;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_IDX_ANGLE;
    cfg_wdata     = '0;
    in_pt.valid   = 1'b0;
    in_pt.x_in    = '0;
    in_pt.y_in    = '0;
    in_pt.z_in    = '0;
    send_idle_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed: rails, every axis, quadrant edges ----
    // zero angle still goes through the CORDIC
    set_rotation(16'h0000, AXIS_Z, '0);
    send_word(C_MAX, C_MIN, coord_t'(1));
    send_word(coord_t'(-1), coord_t'(0), C_MIN);
    wait_drained();
    // quarter turn about X
    set_rotation(16'h4000, AXIS_X, '0);
    send_word(coord_t'(1), C_MAX, C_MIN);
    send_word(coord_t'(0), coord_t'(-1), C_MAX);
    wait_drained();
    // half turn about Y, negating the rails
    set_rotation(16'h8000, AXIS_Y, '0);
    send_word(C_MIN, coord_t'(5), C_MAX);
    send_word(C_MAX, coord_t'(-7), C_MIN);
    wait_drained();
    // eighth turn about Z: corner points grow by sqrt(2) and clamp
    set_rotation(16'h2000, AXIS_Z, '0);
    send_word(C_MAX, C_MAX, coord_t'(0));
    send_word(C_MIN, C_MIN, coord_t'(-1));
    send_word(C_MAX, C_MIN, coord_t'(3));
    wait_drained();
    // largest angle
    set_rotation(16'hFFFF, AXIS_X, '0);
    send_word(coord_t'(123456), coord_t'(-654321), C_MIN);
    wait_drained();
    set_rotation(16'hC000, AXIS_Y, '0);
    send_word(C_MAX, coord_t'(0), C_MIN);
    wait_drained();
    set_rotation(16'h6000, AXIS_Z, '0);
    send_word(coord_t'(-4096), coord_t'(4096), coord_t'(0));
    wait_drained();
    // axis code three: point passes untouched
    set_rotation(16'h3039, AXIS_NONE, '0);
    send_word(C_MAX, C_MIN, coord_t'(-1));
    send_word(coord_t'(0), coord_t'(1), coord_t'(2));
    wait_drained();
    // junk in the unused axis bits
    set_rotation(16'hA001, AXIS_X, 16'hFFFC);
    send_word(coord_t'(4096), coord_t'(-8191), coord_t'(77));

    // ---- random phases ----
    // idle modes cycle: none, sender 85%, receiver 85%, both 10%
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      mode = ph % 4;
      wait_drained();
      case (ph)
        0: set_rotation(16'hFFFF, AXIS_X, '0);
        1: set_rotation(16'h0000, AXIS_Y, AW'($urandom));
        2: set_rotation(16'h8000, AXIS_Z, '0);
        3: set_rotation(rand_angle(), AXIS_NONE, '0);
        default: begin
          axis = par_axis_t'($urandom_range(3));
          set_rotation(rand_angle(), axis, AW'($urandom));
        end
      endcase
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 85; end
        default: begin send_idle_pct = 10; recv_stall_pct <= 10; end
      endcase
      for (int w = 0; w < WORDS_PER_PHASE; w++) begin
        // long receiver hold while words keep coming: pipe fills, input stalls
        if (ph == 0 && w == 10) hold_req_n <= hold_req_n + 1;
        send_word(rand_coord(), rand_coord(), rand_coord());
      end
    end

    // ---- wrap up ----
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    wait_drained();
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (fail_count == 0 && in_flight == 0) begin
      $display("** point_axis_rotator_top: PASSED **");
    end else begin
      $display("** point_axis_rotator_top: FAILED **");
    end
    $finish;
  end

endmodule
